/* design/rlte_pkg.sv */
// rlte_pkg: shared types, constants and token helpers for the run-length token encoder
// no dependencies; imported by the front, queue, back and top level and the testbench

package rlte_pkg;

   localparam int MAX_RUN_DEFAULT     = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int MAX_TOKENS          = 5;
   localparam int TOKEN_COUNT_W       = 3;
   localparam int RUN_W               = 4;

   typedef struct packed {
      logic       is_count;
      logic [7:0] value;
   } token_type;

   // all tokens caused by one input word, in order
   typedef struct packed {
      token_type [MAX_TOKENS-1:0] tokens;
      logic [TOKEN_COUNT_W-1:0]   count;
      logic                       last;
   } cmd_type;

   function automatic token_type count_token(input logic [RUN_W-1:0] run_len);
      token_type t;
      t.is_count = 1'b1;
      t.value    = 8'(run_len - RUN_W'(1));
      return t;
   endfunction

   function automatic token_type byte_token(input logic [7:0] b);
      token_type t;
      t.is_count = 1'b0;
      t.value    = b;
      return t;
   endfunction

endpackage

/* design/rlte_front.sv */
// rlte_front: takes input words, tracks the held run and literal state, builds token lists
// depends on rlte_pkg

module rlte_front
   import rlte_pkg::*;
#(
   parameter int MAX_RUN = MAX_RUN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_text,
   output logic       cmd_push,
   output cmd_type    cmd
);

   localparam logic [RUN_W-1:0] RUN_LIMIT = RUN_W'(MAX_RUN);

   logic [7:0]       held_ff, held_in;
   logic [RUN_W-1:0] run_ff, run_in;
   logic             lit_ff, lit_in;

   always_comb begin
      logic [TOKEN_COUNT_W-1:0] n;
      cmd     = '0;
      n       = '0;
      held_in = held_ff;
      run_in  = run_ff;
      lit_in  = lit_ff;

      if (run_ff == '0) begin
         held_in = in_byte;
         run_in  = RUN_W'(1);
      end else if (in_byte == held_ff && run_ff < RUN_LIMIT) begin
         if (run_ff == RUN_W'(1) && lit_ff) begin
            cmd.tokens[n] = count_token(RUN_W'(1));
            n             = n + TOKEN_COUNT_W'(1);
            lit_in        = 1'b0;
         end
         run_in = run_ff + RUN_W'(1);
      end else begin
         if (run_ff >= RUN_W'(2)) begin
            cmd.tokens[n] = count_token(run_ff);
            n             = n + TOKEN_COUNT_W'(1);
         end else if (!lit_ff) begin
            cmd.tokens[n] = count_token(RUN_W'(1));
            n             = n + TOKEN_COUNT_W'(1);
            lit_in        = 1'b1;
         end
         cmd.tokens[n] = byte_token(held_ff);
         n             = n + TOKEN_COUNT_W'(1);
         held_in       = in_byte;
         run_in        = RUN_W'(1);
      end

      // flush on end of text
      if (end_of_text) begin
         if (run_in >= RUN_W'(2)) begin
            cmd.tokens[n] = count_token(run_in);
            n             = n + TOKEN_COUNT_W'(1);
         end else if (!lit_in) begin
            cmd.tokens[n] = count_token(RUN_W'(1));
            n             = n + TOKEN_COUNT_W'(1);
            lit_in        = 1'b1;
         end
         cmd.tokens[n] = byte_token(held_in);
         n             = n + TOKEN_COUNT_W'(1);
         if (lit_in) begin
            cmd.tokens[n] = count_token(RUN_W'(1));
            n             = n + TOKEN_COUNT_W'(1);
         end
         held_in = '0;
         run_in  = '0;
         lit_in  = 1'b0;
      end

      cmd.count = n;
      cmd.last  = end_of_text;
   end

   assign cmd_push = accept && (cmd.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         run_ff  <= '0;
         lit_ff  <= 1'b0;
      end else if (accept) begin
         held_ff <= held_in;
         run_ff  <= run_in;
         lit_ff  <= lit_in;
      end
   end

endmodule

/* design/rlte_queue.sv */
// rlte_queue: short register queue of token lists between front and back
// depends on rlte_pkg

module rlte_queue
   import rlte_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output cmd_type head_cmd,
   output logic    empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   cmd_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

/* design/rlte_back.sv */
// rlte_back: walks the queue head's token list, one token a cycle into a free result register
// depends on rlte_pkg

module rlte_back
   import rlte_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head_cmd,
   input  logic       head_empty,
   output logic       head_pop,
   output logic       out_empty,
   input  logic       out_pop,
   output logic       out_is_count,
   output logic [7:0] out_token_value,
   output logic       out_final_token
);

   logic [TOKEN_COUNT_W-1:0] idx_ff, idx_in;
   logic                     valid_ff, valid_in;
   logic                     send;
   logic                     at_end;
   token_type                tok;

   assign send     = !head_empty && (!valid_ff || out_pop);
   assign at_end   = (idx_ff == head_cmd.count - TOKEN_COUNT_W'(1));
   assign tok      = head_cmd.tokens[idx_ff];
   assign head_pop = send && at_end;
   assign valid_in = send || (valid_ff && !out_pop);
   assign idx_in   = !send ? idx_ff : (at_end ? '0 : idx_ff + TOKEN_COUNT_W'(1));
   assign out_empty = !valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (send) begin
         out_is_count    <= tok.is_count;
         out_token_value <= tok.value;
         out_final_token <= head_cmd.last && at_end;
      end
   end

endmodule

/* design/run_length_token_encoder.sv */
// run_length_token_encoder: top level, front classifier, token queue and back emitter
// each accepted word's token list is queued, then sent token by token to the result
// throughput: one input word a cycle while the queue has room; one token a cycle out,
//   while the receiver pops, set by the back end
// reset: synchronous, clears run state, queue and result register; no clearing pass
// depends on rlte_pkg, rlte_front, rlte_queue, rlte_back

module run_length_token_encoder
   import rlte_pkg::*;
#(
   parameter int MAX_RUN     = MAX_RUN_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_text,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic       rsp_is_count,
   output logic [7:0] rsp_token_value,
   output logic       rsp_final_token
);

   logic    accept;
   logic    q_push, q_full, q_pop, q_empty;
   cmd_type front_cmd, head_cmd;

   assign accept   = req_push && !q_full;
   assign req_full = q_full;

   rlte_front #(
      .MAX_RUN (MAX_RUN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .in_byte     (req_in_byte),
      .end_of_text (req_end_of_text),
      .cmd_push    (q_push),
      .cmd         (front_cmd)
   );

   rlte_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (front_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .empty    (q_empty)
   );

   rlte_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .head_empty      (q_empty),
      .head_pop        (q_pop),
      .out_empty       (rsp_empty),
      .out_pop         (rsp_pop),
      .out_is_count    (rsp_is_count),
      .out_token_value (rsp_token_value),
      .out_final_token (rsp_final_token)
   );

endmodule

/* design/rlte_checker.sv */
// rlte_checker: port-level assertions for run_length_token_encoder, bound to the top level
// depends on run_length_token_encoder

module rlte_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_push,
   input logic       req_full,
   input logic [7:0] req_in_byte,
   input logic       req_end_of_text,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic       rsp_is_count,
   input logic [7:0] rsp_token_value,
   input logic       rsp_final_token
);

   // no word waits right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // a waiting word holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_is_count) && $stable(rsp_token_value)
          && $stable(rsp_final_token)))
      else $error("waiting word changed before pop");

   // count tokens carry count minus one, at most seven
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_is_count) |-> (rsp_token_value[7:3] == 5'd0))
      else $error("count token out of range");

   // a final count token can only close a literal run
   a_final_close: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_final_token && rsp_is_count) |-> (rsp_token_value == 8'd0))
      else $error("final count token is not a literal close");

endmodule

bind run_length_token_encoder rlte_checker u_rlte_checker (.*);

/* verif/tb_run_length_token_encoder.sv */
// tb_run_length_token_encoder: self-checking testbench for the run-length token encoder
// predicts tokens per accepted byte and checks every popped word in order
// depends on rlte_pkg and run_length_token_encoder

`timescale 1ns / 1ps

module tb_run_length_token_encoder;
   import rlte_pkg::*;

   localparam int RUN_LIMIT  = MAX_RUN_DEFAULT;
   localparam int IDLE_LIMIT = 1000;
   localparam int HOLD_LEN   = 80;
   localparam int SETTLE     = 8;

   typedef struct packed {
      token_type tok;
      logic      last_tok;
   } exp_token_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic       rsp_is_count;
   logic [7:0] rsp_token_value;
   logic       rsp_final_token;

   exp_token_type    expected_tokens[$];
   logic [7:0]       held_byte = 8'h00;
   logic [RUN_W-1:0] run_len = '0;
   logic             lit_open = 1'b0;

   int   err_count = 0;
   int   items_sent = 0;
   int   idle_cycles = 0;
   bit   tx_fast = 1'b0;
   logic rx_fast = 1'b0;
   int   holds_asked = 0;
   int   holds_done = 0;
   int   hold_left = 0;
   int   stall_left = 0;

   run_length_token_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_in_byte     (req_in_byte),
      .req_end_of_text (req_end_of_text),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_is_count    (rsp_is_count),
      .rsp_token_value (rsp_token_value),
      .rsp_final_token (rsp_final_token)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned exp_v,
                                  input int unsigned got_v);
      if (err_count < 50) begin
         $display("mismatch %s: expected %0h got %0h at %0t", what, exp_v, got_v, $realtime);
      end
      err_count++;
   endtask

   // predictor
   task automatic add_token(input logic is_cnt, input logic [7:0] value);
      exp_token_type t;
      t.tok.is_count = is_cnt;
      t.tok.value    = value;
      t.last_tok     = 1'b0;
      expected_tokens.push_back(t);
   endtask

   task automatic flush_held();
      if (run_len >= 2) begin
         add_token(1'b1, 8'(run_len - 1));
         add_token(1'b0, held_byte);
      end else if (run_len == 1) begin
         if (!lit_open) begin
            add_token(1'b1, 8'h00);
            lit_open = 1'b1;
         end
         add_token(1'b0, held_byte);
      end
   endtask

   task automatic encode_byte(input logic [7:0] b, input logic eot);
      int first;
      exp_token_type t;
      first = expected_tokens.size();
      if (run_len == 0) begin
         held_byte = b;
         run_len   = RUN_W'(1);
      end else if (b == held_byte && run_len < RUN_LIMIT) begin
         if (run_len == 1 && lit_open) begin
            add_token(1'b1, 8'h00);
            lit_open = 1'b0;
         end
         run_len = run_len + 1'b1;
      end else begin
         flush_held();
         held_byte = b;
         run_len   = RUN_W'(1);
      end
      if (eot) begin
         flush_held();
         if (lit_open) begin
            add_token(1'b1, 8'h00);
         end
         if (expected_tokens.size() > first) begin
            t = expected_tokens.pop_back();
            t.last_tok = 1'b1;
            expected_tokens.push_back(t);
         end
         held_byte = 8'h00;
         run_len   = '0;
         lit_open  = 1'b0;
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_tokens
      exp_token_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_tokens.size() == 0) begin
            report_mismatch("unexpected word", 0, 32'({rsp_is_count, rsp_token_value}));
         end else begin
            e = expected_tokens.pop_front();
            if (rsp_is_count !== e.tok.is_count) begin
               report_mismatch("is_count", 32'(e.tok.is_count), 32'(rsp_is_count));
            end
            if (rsp_token_value !== e.tok.value) begin
               report_mismatch("token_value", 32'(e.tok.value), 32'(rsp_token_value));
            end
            if (rsp_final_token !== e.last_tok) begin
               report_mismatch("final_token", 32'(e.last_tok), 32'(rsp_final_token));
            end
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      if (holds_asked != holds_done) begin
         hold_left  = HOLD_LEN;
         holds_done = holds_done + 1;
      end
      if (rsp_pop && !rsp_empty) begin
         stall_left = rx_fast ? 0 : $urandom_range(0, 11);
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eot);
      int gap;
      gap = tx_fast ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push        <= 1'b1;
      req_in_byte     <= b;
      req_end_of_text <= eot;
      do @(posedge clock); while (req_full);
      encode_byte(b, eot);
      items_sent++;
   endtask

   task automatic send_run(input logic [7:0] b, input int n, input logic eot_last);
      for (int i = 0; i < n; i++) begin
         send_word(b, eot_last && (i == n - 1));
      end
   endtask

   task automatic stop_and_drain();
      req_push <= 1'b0;
      do @(posedge clock); while (expected_tokens.size() != 0);
   endtask

   function automatic logic [7:0] pick_byte();
      return $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(65, 68));
   endfunction

   // text built from runs of random length and content
   task automatic send_text(input int len);
      int rep_pct;
      logic [7:0] b;
      case ($urandom_range(0, 3))
         0: rep_pct = 0;
         1: rep_pct = 40;
         2: rep_pct = 75;
         default: rep_pct = 90;
      endcase
      b = pick_byte();
      for (int i = 0; i < len; i++) begin
         if (i > 0 && $urandom_range(0, 99) >= rep_pct) begin
            b = pick_byte();
         end
         send_word(b, i == len - 1);
      end
   endtask

   task automatic test_single_byte();
      send_word(8'h00, 1'b1);
   endtask

   task automatic test_run_of_two();
      send_run(8'hFF, 2, 1'b1);
   endtask

   task automatic test_literal_into_run();
      send_word(8'h12, 1'b0);
      send_run(8'h34, 2, 1'b0);
      send_word(8'h56, 1'b1);
   endtask

   task automatic test_run_cut();
      send_run(8'hA5, 9, 1'b0);
      send_word(8'h5A, 1'b1);
   endtask

   task automatic test_full_run_at_end();
      send_run(8'h3C, RUN_LIMIT, 1'b1);
   endtask

   task automatic test_random_texts();
      int start;
      start = items_sent;
      while (items_sent - start < 250) begin
         tx_fast = ($urandom_range(0, 3) == 0);
         rx_fast <= ($urandom_range(0, 3) == 0);
         send_text($urandom_range(0, 7) == 0 ? $urandom_range(20, 40) : $urandom_range(1, 20));
      end
      tx_fast = 1'b0;
      rx_fast <= 1'b0;
   endtask

   task automatic test_noise();
      for (int i = 0; i < 40; i++) begin
         send_word(8'($urandom), $urandom_range(0, 7) == 0);
      end
      send_word(8'($urandom), 1'b1);
   endtask

   task automatic test_receiver_hold();
      holds_asked <= holds_asked + 1;
      tx_fast = 1'b1;
      for (int i = 0; i < 30; i++) begin
         send_word(8'($urandom), i == 29);
      end
      tx_fast = 1'b0;
   endtask

   task automatic test_sender_pause();
      send_text(10);
      send_word(8'h77, 1'b0);
      stop_and_drain();
      send_word(8'h77, 1'b0);
      send_text(10);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_single_byte();
      test_run_of_two();
      test_literal_into_run();
      test_run_cut();
      test_full_run_at_end();
      test_random_texts();
      test_noise();
      test_receiver_hold();
      test_sender_pause();
      stop_and_drain();
      repeat (SETTLE) @(posedge clock);
      if (err_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/rlte_pkg.sv
design/rlte_front.sv
design/rlte_queue.sv
design/rlte_back.sv
design/run_length_token_encoder.sv
design/rlte_checker.sv
verif/tb_run_length_token_encoder.sv
